### rtl/sia_pkg.sv
// Package with the shared constants, register map and result type of the interlock unit.
`timescale 1ns / 1ps

package sia_pkg;

    // Moving average length, a power of two so the divide is a shift.
    localparam int AVG_DEPTH = 16;
    localparam int AVG_BITS  = $clog2(AVG_DEPTH);
    localparam int MV_W      = 12;
    localparam int SUM_W     = MV_W + AVG_BITS;
    localparam int DELAY_W   = 8;
    localparam int ADDR_W    = 5;

    localparam logic [DELAY_W-1:0] CNT_MAX = {DELAY_W{1'b1}};

    // Register indexes (byte address is four times the index).
    typedef enum logic [2:0] {
        REG_LIGHT_DAY   = 3'd0,
        REG_LIGHT_DUSK  = 3'd1,
        REG_KNOB_OFF    = 3'd2,
        REG_KNOB_ON     = 3'd3,
        REG_ON_DELAY    = 3'd4,
        REG_OFF_DELAY   = 3'd5
    } t_reg_idx;

    localparam logic [MV_W-1:0]    RST_LIGHT_DAY  = 12'd1722;
    localparam logic [MV_W-1:0]    RST_LIGHT_DUSK = 12'd880;
    localparam logic [MV_W-1:0]    RST_KNOB_OFF   = 12'd1365;
    localparam logic [MV_W-1:0]    RST_KNOB_ON    = 12'd2730;
    localparam logic [DELAY_W-1:0] RST_ON_DELAY   = 8'd20;
    localparam logic [DELAY_W-1:0] RST_OFF_DELAY  = 8'd40;

    typedef enum logic [1:0] {
        MODE_ENGINE_OFF = 2'd0,
        MODE_FORCED_OFF = 2'd1,
        MODE_FORCED_ON  = 2'd2,
        MODE_AUTO       = 2'd3
    } t_lamp_mode;

    typedef struct packed {
        logic             start_allowed_led;
        logic             engine_led;
        logic             inhibit_beep;
        logic [3:0]       missing_mask;
        logic             engine_started;
        logic             engine_stopped;
        logic             welcome_event;
        logic             headlights;
        t_lamp_mode       lamp_mode;
        logic [MV_W-1:0]  knob_average;
        logic [MV_W-1:0]  light_average;
    } t_result;

endpackage

### rtl/sia_avg.sv
// Moving average over a ring of samples kept as a running sum.
`timescale 1ns / 1ps

module sia_avg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [sia_pkg::MV_W-1:0] i_sample,
    output logic [sia_pkg::MV_W-1:0] o_average
);

    logic [sia_pkg::MV_W-1:0]     r_ring [sia_pkg::AVG_DEPTH];
    logic [sia_pkg::SUM_W-1:0]    r_sum;
    logic [sia_pkg::AVG_BITS-1:0] r_pos;
    logic [sia_pkg::SUM_W-1:0]    n_sum;

    // The sum never exceeds depth times the largest sample, so it cannot wrap.
    assign n_sum = r_sum - sia_pkg::SUM_W'(r_ring[r_pos])
                 + sia_pkg::SUM_W'(i_sample);
    assign o_average = n_sum[sia_pkg::SUM_W-1:sia_pkg::AVG_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_pos <= '0;
            for (int i = 0; i < sia_pkg::AVG_DEPTH; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_push) begin
            r_sum         <= n_sum;
            r_ring[r_pos] <= i_sample;
            r_pos         <= r_pos + 1'b1;
        end
    end

endmodule

### rtl/seatbelt_interlock_auto_headlight_unit.sv
// Top level of the seatbelt interlock and automatic headlight unit.
`timescale 1ns / 1ps

// Each input transaction is one 50 ms tick and yields exactly one result
// transaction. The block takes one tick per clock cycle: the tick is evaluated
// combinationally from the input ports and the state registers and lands in a
// two-entry output buffer, in the head register or, while the head is stalled,
// in the skid entry. Input is only held off while both buffer entries are full.
// The two 16-sample averaging rings start out cleared after reset, so the
// averages ramp up over the first 16 ticks. Thresholds and delays are set
// through the APB port at byte addresses 0x00 to 0x14 and should be written
// only while no tick is in flight.
module seatbelt_interlock_auto_headlight_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sia_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Tick input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_driver_seated,
    input  logic                          i_passenger_seated,
    input  logic                          i_driver_belted,
    input  logic                          i_passenger_belted,
    input  logic                          i_ignition_button,
    input  logic [sia_pkg::MV_W-1:0]      i_knob_mv,
    input  logic [sia_pkg::MV_W-1:0]      i_light_mv,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_start_allowed_led,
    output logic                          o_engine_led,
    output logic                          o_inhibit_beep,
    output logic [3:0]                    o_missing_mask,
    output logic                          o_engine_started,
    output logic                          o_engine_stopped,
    output logic                          o_welcome_event,
    output logic                          o_headlights,
    output logic [1:0]                    o_lamp_mode,
    output logic [sia_pkg::MV_W-1:0]      o_knob_average,
    output logic [sia_pkg::MV_W-1:0]      o_light_average
);

    // Configuration registers
    logic [sia_pkg::MV_W-1:0]    r_light_day;
    logic [sia_pkg::MV_W-1:0]    r_light_dusk;
    logic [sia_pkg::MV_W-1:0]    r_knob_off;
    logic [sia_pkg::MV_W-1:0]    r_knob_on;
    logic [sia_pkg::DELAY_W-1:0] r_on_delay;
    logic [sia_pkg::DELAY_W-1:0] r_off_delay;

    logic             cfg_wr;
    sia_pkg::t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = sia_pkg::t_reg_idx'(paddr[sia_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_day  <= sia_pkg::RST_LIGHT_DAY;
            r_light_dusk <= sia_pkg::RST_LIGHT_DUSK;
            r_knob_off   <= sia_pkg::RST_KNOB_OFF;
            r_knob_on    <= sia_pkg::RST_KNOB_ON;
            r_on_delay   <= sia_pkg::RST_ON_DELAY;
            r_off_delay  <= sia_pkg::RST_OFF_DELAY;
        end else if (cfg_wr) begin
            case (cfg_idx)
                sia_pkg::REG_LIGHT_DAY:  r_light_day  <= pwdata[sia_pkg::MV_W-1:0];
                sia_pkg::REG_LIGHT_DUSK: r_light_dusk <= pwdata[sia_pkg::MV_W-1:0];
                sia_pkg::REG_KNOB_OFF:   r_knob_off   <= pwdata[sia_pkg::MV_W-1:0];
                sia_pkg::REG_KNOB_ON:    r_knob_on    <= pwdata[sia_pkg::MV_W-1:0];
                sia_pkg::REG_ON_DELAY:   r_on_delay   <= pwdata[sia_pkg::DELAY_W-1:0];
                sia_pkg::REG_OFF_DELAY:  r_off_delay  <= pwdata[sia_pkg::DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            sia_pkg::REG_LIGHT_DAY:  prdata = 32'(r_light_day);
            sia_pkg::REG_LIGHT_DUSK: prdata = 32'(r_light_dusk);
            sia_pkg::REG_KNOB_OFF:   prdata = 32'(r_knob_off);
            sia_pkg::REG_KNOB_ON:    prdata = 32'(r_knob_on);
            sia_pkg::REG_ON_DELAY:   prdata = 32'(r_on_delay);
            sia_pkg::REG_OFF_DELAY:  prdata = 32'(r_off_delay);
            default:                 prdata = '0;
        endcase
    end

    // Tick evaluation
    logic in_acc;
    logic [sia_pkg::MV_W-1:0] knob_avg;
    logic [sia_pkg::MV_W-1:0] light_avg;

    assign in_acc = i_in_valid && o_in_ready;

    sia_avg u_knob_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_acc),
        .i_sample  (i_knob_mv),
        .o_average (knob_avg)
    );

    sia_avg u_light_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (in_acc),
        .i_sample  (i_light_mv),
        .o_average (light_avg)
    );

    logic r_engine_on, r_prev_ign, r_prev_dseat, r_greeted, r_lamp_latch;
    logic [sia_pkg::DELAY_W-1:0] r_dark_cnt, r_bright_cnt;
    logic n_engine_on, n_greeted, n_lamp_latch;
    logic [sia_pkg::DELAY_W-1:0] n_dark_cnt, n_bright_cnt;
    logic [sia_pkg::DELAY_W-1:0] dark_inc, bright_inc;
    logic safe, ign_edge;
    sia_pkg::t_result res;

    assign safe     = i_driver_seated && i_passenger_seated
                   && i_driver_belted && i_passenger_belted;
    assign ign_edge = i_ignition_button && !r_prev_ign;
    assign dark_inc   = (r_dark_cnt == sia_pkg::CNT_MAX) ? r_dark_cnt : r_dark_cnt + 1'b1;
    assign bright_inc = (r_bright_cnt == sia_pkg::CNT_MAX) ? r_bright_cnt
                                                            : r_bright_cnt + 1'b1;

    always_comb begin
        res = '0;
        res.start_allowed_led = !r_engine_on && safe && !ign_edge;
        res.welcome_event     = i_driver_seated && !r_prev_dseat && !r_greeted;
        res.knob_average      = knob_avg;
        res.light_average     = light_avg;
        n_greeted   = r_greeted || res.welcome_event;
        n_engine_on = r_engine_on;

        if (ign_edge) begin
            if (r_engine_on) begin
                n_engine_on        = 1'b0;
                res.engine_stopped = 1'b1;
            end else if (safe) begin
                n_engine_on        = 1'b1;
                res.engine_started = 1'b1;
            end else begin
                res.inhibit_beep = 1'b1;
                res.missing_mask = {!i_passenger_belted, !i_driver_belted,
                                    !i_passenger_seated, !i_driver_seated};
            end
        end

        n_lamp_latch  = r_lamp_latch;
        n_dark_cnt    = '0;
        n_bright_cnt  = '0;
        res.lamp_mode = sia_pkg::MODE_ENGINE_OFF;
        if (!n_engine_on) begin
            n_lamp_latch = 1'b0;
        end else if (knob_avg >= r_knob_on) begin
            res.lamp_mode = sia_pkg::MODE_FORCED_ON;
            n_lamp_latch  = 1'b1;
        end else if (knob_avg <= r_knob_off) begin
            res.lamp_mode = sia_pkg::MODE_FORCED_OFF;
            n_lamp_latch  = 1'b0;
        end else begin
            res.lamp_mode = sia_pkg::MODE_AUTO;
            // Dusk is tested first, so it wins when the thresholds overlap.
            if (light_avg < r_light_dusk) begin
                n_dark_cnt = dark_inc;
                if (dark_inc >= r_on_delay) begin
                    n_lamp_latch = 1'b1;
                end
            end else if (light_avg > r_light_day) begin
                n_bright_cnt = bright_inc;
                if (bright_inc >= r_off_delay) begin
                    n_lamp_latch = 1'b0;
                end
            end
        end

        res.engine_led = n_engine_on;
        res.headlights = n_engine_on && n_lamp_latch;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_engine_on  <= 1'b0;
            r_prev_ign   <= 1'b0;
            r_prev_dseat <= 1'b0;
            r_greeted    <= 1'b0;
            r_lamp_latch <= 1'b1;
            r_dark_cnt   <= '0;
            r_bright_cnt <= '0;
        end else if (in_acc) begin
            r_engine_on  <= n_engine_on;
            r_prev_ign   <= i_ignition_button;
            r_prev_dseat <= i_driver_seated;
            r_greeted    <= n_greeted;
            r_lamp_latch <= n_lamp_latch;
            r_dark_cnt   <= n_dark_cnt;
            r_bright_cnt <= n_bright_cnt;
        end
    end

    // Two-entry result buffer: a head register feeding the ports and a skid
    // entry that catches one more result while the head is stalled.
    sia_pkg::t_result r_head, r_skid;
    logic r_head_valid, r_skid_valid;
    logic head_load;

    assign o_in_ready = !r_skid_valid;
    assign head_load  = !r_head_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (head_load) begin
            r_head_valid <= r_skid_valid || in_acc;
            r_skid_valid <= r_skid_valid && in_acc;
        end else if (in_acc) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (head_load) begin
            if (r_skid_valid) begin
                r_head <= r_skid;
            end else if (in_acc) begin
                r_head <= res;
            end
        end
        if (in_acc && (r_skid_valid || !head_load)) begin
            r_skid <= res;
        end
    end

    assign o_out_valid         = r_head_valid;
    assign o_start_allowed_led = r_head.start_allowed_led;
    assign o_engine_led        = r_head.engine_led;
    assign o_inhibit_beep      = r_head.inhibit_beep;
    assign o_missing_mask      = r_head.missing_mask;
    assign o_engine_started    = r_head.engine_started;
    assign o_engine_stopped    = r_head.engine_stopped;
    assign o_welcome_event     = r_head.welcome_event;
    assign o_headlights        = r_head.headlights;
    assign o_lamp_mode         = r_head.lamp_mode;
    assign o_knob_average      = r_head.knob_average;
    assign o_light_average     = r_head.light_average;

endmodule

### tb/seatbelt_interlock_auto_headlight_unit_test.sv
// Self-checking testbench for the seatbelt interlock and automatic headlight unit.
`timescale 1ns / 1ps

module seatbelt_interlock_auto_headlight_unit_test;

    // Indexes past the register map; writes there must leave every register alone.
    localparam logic [2:0] SPARE_IDX_A = 3'd6;
    localparam logic [2:0] SPARE_IDX_B = 3'd7;

    typedef struct packed {
        logic                     dseat;
        logic                     pseat;
        logic                     dbelt;
        logic                     pbelt;
        logic                     ign;
        logic [sia_pkg::MV_W-1:0] knob;
        logic [sia_pkg::MV_W-1:0] light;
    } t_tick;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [sia_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_driver_seated;
    logic                          i_passenger_seated;
    logic                          i_driver_belted;
    logic                          i_passenger_belted;
    logic                          i_ignition_button;
    logic [sia_pkg::MV_W-1:0]      i_knob_mv;
    logic [sia_pkg::MV_W-1:0]      i_light_mv;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    logic                          o_start_allowed_led;
    logic                          o_engine_led;
    logic                          o_inhibit_beep;
    logic [3:0]                    o_missing_mask;
    logic                          o_engine_started;
    logic                          o_engine_stopped;
    logic                          o_welcome_event;
    logic                          o_headlights;
    logic [1:0]                    o_lamp_mode;
    logic [sia_pkg::MV_W-1:0]      o_knob_average;
    logic [sia_pkg::MV_W-1:0]      o_light_average;

    // Predictor state and its copy of the register file.
    logic [sia_pkg::MV_W-1:0]      knob_hist [sia_pkg::AVG_DEPTH];
    logic [sia_pkg::MV_W-1:0]      light_hist [sia_pkg::AVG_DEPTH];
    logic [sia_pkg::SUM_W-1:0]     knob_total;
    logic [sia_pkg::SUM_W-1:0]     light_total;
    logic [sia_pkg::AVG_BITS-1:0]  hist_idx;
    logic                          eng_running;
    logic                          ign_last;
    logic                          dseat_last;
    logic                          welcomed;
    logic                          beam_latch;
    logic [sia_pkg::DELAY_W-1:0]   dusk_run;
    logic [sia_pkg::DELAY_W-1:0]   day_run;
    logic [sia_pkg::MV_W-1:0]      th_day, th_dusk, th_knob_off, th_knob_on;
    logic [sia_pkg::DELAY_W-1:0]   dly_on, dly_off;

    sia_pkg::t_result              tick_outcomes [$];
    sia_pkg::t_result              want_res;
    int                            mismatch_count = 0;
    int                            items_sent = 0;
    logic                          steady = 1'b0;

    seatbelt_interlock_auto_headlight_unit u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_driver_seated     (i_driver_seated),
        .i_passenger_seated  (i_passenger_seated),
        .i_driver_belted     (i_driver_belted),
        .i_passenger_belted  (i_passenger_belted),
        .i_ignition_button   (i_ignition_button),
        .i_knob_mv           (i_knob_mv),
        .i_light_mv          (i_light_mv),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_start_allowed_led (o_start_allowed_led),
        .o_engine_led        (o_engine_led),
        .o_inhibit_beep      (o_inhibit_beep),
        .o_missing_mask      (o_missing_mask),
        .o_engine_started    (o_engine_started),
        .o_engine_stopped    (o_engine_stopped),
        .o_welcome_event     (o_welcome_event),
        .o_headlights        (o_headlights),
        .o_lamp_mode         (o_lamp_mode),
        .o_knob_average      (o_knob_average),
        .o_light_average     (o_light_average)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("** seatbelt_interlock_auto_headlight_unit: FAILED **");
        $finish;
    end

    function automatic void clear_predictor();
        for (int i = 0; i < sia_pkg::AVG_DEPTH; i++) begin
            knob_hist[i]  = '0;
            light_hist[i] = '0;
        end
        knob_total  = '0;
        light_total = '0;
        hist_idx    = '0;
        eng_running = 1'b0;
        ign_last    = 1'b0;
        dseat_last  = 1'b0;
        welcomed    = 1'b0;
        beam_latch  = 1'b1;
        dusk_run    = '0;
        day_run     = '0;
        th_day      = sia_pkg::RST_LIGHT_DAY;
        th_dusk     = sia_pkg::RST_LIGHT_DUSK;
        th_knob_off = sia_pkg::RST_KNOB_OFF;
        th_knob_on  = sia_pkg::RST_KNOB_ON;
        dly_on      = sia_pkg::RST_ON_DELAY;
        dly_off     = sia_pkg::RST_OFF_DELAY;
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            sia_pkg::REG_LIGHT_DAY:  th_day      = data[sia_pkg::MV_W-1:0];
            sia_pkg::REG_LIGHT_DUSK: th_dusk     = data[sia_pkg::MV_W-1:0];
            sia_pkg::REG_KNOB_OFF:   th_knob_off = data[sia_pkg::MV_W-1:0];
            sia_pkg::REG_KNOB_ON:    th_knob_on  = data[sia_pkg::MV_W-1:0];
            sia_pkg::REG_ON_DELAY:   dly_on      = data[sia_pkg::DELAY_W-1:0];
            sia_pkg::REG_OFF_DELAY:  dly_off     = data[sia_pkg::DELAY_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] reg_value(input logic [2:0] idx);
        case (idx)
            sia_pkg::REG_LIGHT_DAY:  return 32'(th_day);
            sia_pkg::REG_LIGHT_DUSK: return 32'(th_dusk);
            sia_pkg::REG_KNOB_OFF:   return 32'(th_knob_off);
            sia_pkg::REG_KNOB_ON:    return 32'(th_knob_on);
            sia_pkg::REG_ON_DELAY:   return 32'(dly_on);
            sia_pkg::REG_OFF_DELAY:  return 32'(dly_off);
            default:                 return '0;
        endcase
    endfunction

    // Advances the predicted state by one tick and returns the outcome it should produce.
    function automatic sia_pkg::t_result evaluate_tick(input t_tick t);
        sia_pkg::t_result         r;
        logic [sia_pkg::MV_W-1:0] k_avg;
        logic [sia_pkg::MV_W-1:0] l_avg;
        logic                     all_set;
        logic                     press;
        r = '0;
        knob_total  = knob_total - knob_hist[hist_idx] + t.knob;
        light_total = light_total - light_hist[hist_idx] + t.light;
        knob_hist[hist_idx]  = t.knob;
        light_hist[hist_idx] = t.light;
        hist_idx = hist_idx + 1'b1;
        k_avg = sia_pkg::MV_W'(knob_total / sia_pkg::AVG_DEPTH);
        l_avg = sia_pkg::MV_W'(light_total / sia_pkg::AVG_DEPTH);

        all_set = t.dseat & t.pseat & t.dbelt & t.pbelt;
        press   = t.ign & ~ign_last;
        r.welcome_event     = t.dseat & ~dseat_last & ~welcomed;
        r.start_allowed_led = ~eng_running & all_set & ~press;
        if (r.welcome_event) begin
            welcomed = 1'b1;
        end
        dseat_last = t.dseat;

        if (press) begin
            if (eng_running) begin
                eng_running      = 1'b0;
                r.engine_stopped = 1'b1;
            end else if (all_set) begin
                eng_running      = 1'b1;
                r.engine_started = 1'b1;
            end else begin
                r.inhibit_beep = 1'b1;
                r.missing_mask = ~{t.pbelt, t.dbelt, t.pseat, t.dseat};
            end
        end
        ign_last = t.ign;

        r.lamp_mode = sia_pkg::MODE_ENGINE_OFF;
        if (!eng_running) begin
            beam_latch = 1'b0;
            dusk_run   = '0;
            day_run    = '0;
        end else if (k_avg >= th_knob_on) begin
            r.lamp_mode = sia_pkg::MODE_FORCED_ON;
            beam_latch  = 1'b1;
            dusk_run    = '0;
            day_run     = '0;
        end else if (k_avg <= th_knob_off) begin
            r.lamp_mode = sia_pkg::MODE_FORCED_OFF;
            beam_latch  = 1'b0;
            dusk_run    = '0;
            day_run     = '0;
        end else begin
            r.lamp_mode = sia_pkg::MODE_AUTO;
            // The dusk test comes first, so it wins when the thresholds overlap.
            if (l_avg < th_dusk) begin
                if (dusk_run != sia_pkg::CNT_MAX) begin
                    dusk_run++;
                end
                day_run = '0;
                if (dusk_run >= dly_on) begin
                    beam_latch = 1'b1;
                end
            end else if (l_avg > th_day) begin
                if (day_run != sia_pkg::CNT_MAX) begin
                    day_run++;
                end
                dusk_run = '0;
                if (day_run >= dly_off) begin
                    beam_latch = 1'b0;
                end
            end else begin
                dusk_run = '0;
                day_run  = '0;
            end
        end

        r.engine_led    = eng_running;
        r.headlights    = eng_running & beam_latch;
        r.knob_average  = k_avg;
        r.light_average = l_avg;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
            end
        end
    endfunction

    // Result channel: ready idles at random, and each result transaction is checked in order.
    always @(posedge i_clk) begin
        i_out_ready <= steady || ($urandom_range(99) >= 23);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("%0t: result with no tick outstanding", $time);
                end
            end else begin
                want_res = tick_outcomes.pop_front();
                check_field("start_allowed_led", want_res.start_allowed_led, o_start_allowed_led);
                check_field("engine_led", want_res.engine_led, o_engine_led);
                check_field("inhibit_beep", want_res.inhibit_beep, o_inhibit_beep);
                check_field("missing_mask", want_res.missing_mask, o_missing_mask);
                check_field("engine_started", want_res.engine_started, o_engine_started);
                check_field("engine_stopped", want_res.engine_stopped, o_engine_stopped);
                check_field("welcome_event", want_res.welcome_event, o_welcome_event);
                check_field("headlights", want_res.headlights, o_headlights);
                check_field("lamp_mode", want_res.lamp_mode, o_lamp_mode);
                check_field("knob_average", want_res.knob_average, o_knob_average);
                check_field("light_average", want_res.light_average, o_light_average);
            end
        end
    end

    function automatic t_tick mk_tick(input logic ds, input logic ps, input logic db,
                                      input logic pb, input logic ig,
                                      input logic [sia_pkg::MV_W-1:0] k,
                                      input logic [sia_pkg::MV_W-1:0] l);
        t_tick t;
        t = '{dseat: ds, pseat: ps, dbelt: db, pbelt: pb, ign: ig, knob: k, light: l};
        return t;
    endfunction

    function automatic t_tick random_tick();
        return mk_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)),
                       sia_pkg::MV_W'($urandom_range(0, 4095)),
                       sia_pkg::MV_W'($urandom_range(0, 4095)));
    endfunction

    function automatic logic [sia_pkg::MV_W-1:0] jitter(input logic [sia_pkg::MV_W-1:0] v,
                                                        input int spread);
        int j;
        int x;
        j = $urandom_range(0, 2 * spread);
        x = int'(v) + j - spread;
        if (x < 0) begin
            x = 0;
        end
        if (x > 4095) begin
            x = 4095;
        end
        return x[sia_pkg::MV_W-1:0];
    endfunction

    // Levels are picked against the current thresholds; auto gets the larger share.
    function automatic logic [sia_pkg::MV_W-1:0] pick_knob();
        case ($urandom_range(0, 3))
            0:       return sia_pkg::MV_W'($urandom_range(0, th_knob_off));
            1:       return sia_pkg::MV_W'($urandom_range(th_knob_on, 4095));
            default: return sia_pkg::MV_W'($urandom_range(th_knob_off, th_knob_on));
        endcase
    endfunction

    function automatic logic [sia_pkg::MV_W-1:0] pick_light();
        case ($urandom_range(0, 2))
            0:       return sia_pkg::MV_W'($urandom_range(0, th_dusk));
            1:       return sia_pkg::MV_W'($urandom_range(th_day, 4095));
            default: return sia_pkg::MV_W'($urandom_range(th_dusk, th_day));
        endcase
    endfunction

    // Sends one tick transaction, with random idle cycles ahead of it, and
    // records its predicted outcome at the edge where it is accepted.
    task automatic drive_tick(input t_tick t);
        while (!steady && $urandom_range(99) < 23) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_driver_seated    <= t.dseat;
        i_passenger_seated <= t.pseat;
        i_driver_belted    <= t.dbelt;
        i_passenger_belted <= t.pbelt;
        i_ignition_button  <= t.ign;
        i_knob_mv          <= t.knob;
        i_light_mv         <= t.light;
        do @(posedge i_clk); while (!o_in_ready);
        tick_outcomes.push_back(evaluate_tick(t));
        items_sent++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tick_outcomes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    // One APB transfer. psel stays high afterwards so transfers can run back to back.
    task automatic apb_transfer(input logic wr, input logic [2:0] idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= sia_pkg::ADDR_W'({idx, 2'b00});
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        if (wr) begin
            apply_reg(idx, wdata);
        end
    endtask

    task automatic apb_release();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] day, input logic [31:0] dusk,
                              input logic [31:0] koff, input logic [31:0] kon,
                              input logic [31:0] ond, input logic [31:0] offd);
        logic [31:0] unused;
        wait_idle();
        apb_transfer(1'b1, sia_pkg::REG_LIGHT_DAY, day, unused);
        apb_transfer(1'b1, sia_pkg::REG_LIGHT_DUSK, dusk, unused);
        apb_transfer(1'b1, sia_pkg::REG_KNOB_OFF, koff, unused);
        apb_transfer(1'b1, sia_pkg::REG_KNOB_ON, kon, unused);
        apb_transfer(1'b1, sia_pkg::REG_ON_DELAY, ond, unused);
        apb_transfer(1'b1, sia_pkg::REG_OFF_DELAY, offd, unused);
        apb_release();
    endtask

    // A drive cycle: a little fumbling, buckle up, start, run through level
    // segments of random length around picked knob and light levels, then switch off.
    task automatic run_session(input int run_len, input int max_seg);
        t_tick                    t;
        int                       seg_left;
        logic [sia_pkg::MV_W-1:0] ktgt;
        logic [sia_pkg::MV_W-1:0] ltgt;
        repeat ($urandom_range(0, 3)) drive_tick(random_tick());
        drive_tick(mk_tick(1, 1, 1, 1, 0, pick_knob(), pick_light()));
        repeat ($urandom_range(1, 3)) drive_tick(mk_tick(1, 1, 1, 1, 1, pick_knob(), pick_light()));
        seg_left = 0;
        ktgt = '0;
        ltgt = '0;
        for (int i = 0; i < run_len; i++) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(4, max_seg);
                ktgt = pick_knob();
                ltgt = pick_light();
            end
            seg_left--;
            t = mk_tick(1, 1, 1, 1, 0, jitter(ktgt, 24), jitter(ltgt, 24));
            if ($urandom_range(99) < 5) begin
                t.pbelt = 1'b0;
            end
            if ($urandom_range(99) < 2) begin
                t.ign = 1'b1;
            end
            drive_tick(t);
        end
        drive_tick(mk_tick(1, 1, 1, 1, 1, jitter(ktgt, 24), jitter(ltgt, 24)));
    endtask

    task automatic run_traffic(input int n_ticks, input int max_seg);
        int start;
        start = items_sent;
        while (items_sent - start < n_ticks) begin
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 6)) drive_tick(random_tick());
            end else begin
                run_session($urandom_range(8, 3 * max_seg), max_seg);
            end
        end
    endtask

    task automatic test_register_access();
        logic [31:0] data;
        wait_idle();
        for (int i = sia_pkg::REG_LIGHT_DAY; i <= sia_pkg::REG_OFF_DELAY; i++) begin
            apb_transfer(1'b0, i[2:0], '0, data);
            check_field("reset register value", reg_value(i[2:0]), data);
        end
        // Upper bits of each write are junk and must be dropped.
        for (int i = sia_pkg::REG_LIGHT_DAY; i <= sia_pkg::REG_OFF_DELAY; i++) begin
            apb_transfer(1'b1, i[2:0], $urandom, data);
        end
        apb_transfer(1'b1, SPARE_IDX_A, $urandom, data);
        apb_transfer(1'b1, SPARE_IDX_B, $urandom, data);
        for (int i = sia_pkg::REG_LIGHT_DAY; i <= sia_pkg::REG_OFF_DELAY; i++) begin
            apb_transfer(1'b0, i[2:0], '0, data);
            check_field("register readback", reg_value(i[2:0]), data);
        end
        apb_release();
    endtask

    // The lamp latch comes out of reset set, so a start on the very first
    // tick in auto with mid-range light turns the lamps on at once.
    task automatic test_reset_latch_start();
        set_config(4095, 0, 0, 4095, 20, 40);
        drive_tick(mk_tick(1, 1, 1, 1, 1, 1600, 1600));
        drive_tick(mk_tick(1, 1, 1, 1, 0, 1600, 1600));
        drive_tick(mk_tick(1, 1, 1, 1, 1, 1600, 1600));
    endtask

    task automatic test_directed_ticks();
        set_config(sia_pkg::RST_LIGHT_DAY, sia_pkg::RST_LIGHT_DUSK, sia_pkg::RST_KNOB_OFF,
                   sia_pkg::RST_KNOB_ON, sia_pkg::RST_ON_DELAY, sia_pkg::RST_OFF_DELAY);
        drive_tick(mk_tick(0, 0, 0, 0, 0, 0, 0));
        drive_tick(mk_tick(0, 0, 0, 0, 1, 0, 0));
        drive_tick(mk_tick(1, 0, 0, 0, 0, 0, 0));
        drive_tick(mk_tick(1, 0, 0, 0, 1, 4095, 0));
        drive_tick(mk_tick(0, 0, 0, 0, 0, 4095, 0));
        // Driver sits down again: the welcome does not repeat.
        drive_tick(mk_tick(1, 0, 0, 0, 0, 4095, 0));
        drive_tick(mk_tick(1, 1, 0, 0, 1, 4095, 4095));
        drive_tick(mk_tick(1, 1, 1, 0, 0, 4095, 4095));
        drive_tick(mk_tick(1, 1, 1, 0, 1, 4095, 4095));
        drive_tick(mk_tick(1, 1, 1, 1, 0, 4095, 4095));
        drive_tick(mk_tick(1, 1, 1, 1, 1, 4095, 4095));
        // Button held down: no further edge while the knob average climbs
        // from auto to forced on.
        repeat (10) drive_tick(mk_tick(1, 1, 1, 1, 1, 4095, 4095));
        drive_tick(mk_tick(1, 1, 1, 1, 0, 4095, 4095));
        drive_tick(mk_tick(0, 0, 0, 0, 1, 0, 4095));
        drive_tick(mk_tick(1, 1, 1, 1, 0, 0, 0));
    endtask

    task automatic test_short_delays();
        set_config(sia_pkg::RST_LIGHT_DAY, sia_pkg::RST_LIGHT_DUSK, sia_pkg::RST_KNOB_OFF,
                   sia_pkg::RST_KNOB_ON, 3, 5);
        run_traffic(150, 40);
    endtask

    task automatic test_threshold_extremes();
        set_config(4095, 0, 0, 4095, 0, 0);
        run_traffic(30, 20);
        // Both pairs overlap: forced on and dusk take precedence.
        set_config(0, 4095, 4095, 0, 0, 0);
        run_traffic(30, 20);
        set_config(0, 4095, sia_pkg::RST_KNOB_OFF, sia_pkg::RST_KNOB_ON, 1, 1);
        run_traffic(30, 20);
        set_config(2000, 2000, 2047, 2048, 255, 0);
        run_traffic(30, 20);
        set_config(sia_pkg::RST_LIGHT_DAY, sia_pkg::RST_LIGHT_DUSK, sia_pkg::RST_KNOB_OFF,
                   sia_pkg::RST_KNOB_ON, 0, 255);
        run_traffic(30, 20);
    endtask

    // Long unbroken dusk and daylight runs past 255 ticks, with no idling on either side.
    task automatic test_counter_saturation();
        set_config(sia_pkg::RST_LIGHT_DAY, sia_pkg::RST_LIGHT_DUSK, 0, 4095, 255, 255);
        steady = 1'b1;
        drive_tick(mk_tick(1, 1, 1, 1, 0, 2000, 2000));
        if (eng_running) begin
            drive_tick(mk_tick(1, 1, 1, 1, 1, 2000, 2000));
            drive_tick(mk_tick(1, 1, 1, 1, 0, 2000, 2000));
        end
        drive_tick(mk_tick(1, 1, 1, 1, 1, 2000, 2000));
        repeat (275) drive_tick(mk_tick(1, 1, 1, 1, 0, jitter(2000, 40), jitter(100, 60)));
        repeat (275) drive_tick(mk_tick(1, 1, 1, 1, 0, jitter(2000, 40), jitter(3600, 60)));
        drive_tick(mk_tick(1, 1, 1, 1, 1, 2000, 3600));
        wait_idle();
        steady = 1'b0;
    endtask

    task automatic test_random_settings();
        repeat (3) begin
            set_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            run_traffic(30, 30);
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        i_in_valid         = 1'b0;
        i_driver_seated    = 1'b0;
        i_passenger_seated = 1'b0;
        i_driver_belted    = 1'b0;
        i_passenger_belted = 1'b0;
        i_ignition_button  = 1'b0;
        i_knob_mv          = '0;
        i_light_mv         = '0;
        clear_predictor();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_reset_latch_start();
        test_directed_ticks();
        test_short_delays();
        test_threshold_extremes();
        test_counter_saturation();
        test_random_settings();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("** seatbelt_interlock_auto_headlight_unit: PASSED **");
        end else begin
            $display("** seatbelt_interlock_auto_headlight_unit: FAILED **");
        end
        $finish;
    end

endmodule

### files.f
rtl/sia_pkg.sv
rtl/sia_avg.sv
rtl/seatbelt_interlock_auto_headlight_unit.sv
tb/seatbelt_interlock_auto_headlight_unit_test.sv
